// ===== rtl/pi_line_phasor_companion_step_top_macros.svh =====
// Assertion macros for the pi-line companion step block.
`ifndef PI_LINE_PHASOR_COMPANION_STEP_TOP_MACROS_SVH
`define PI_LINE_PHASOR_COMPANION_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PILPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pilpc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PILPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pilpc assertion failed");

`endif

// ===== rtl/pilpc_pkg.sv =====
package pilpc_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int COEF_W         = 32;
	localparam int COEF_FRAC      = 30;
	localparam int CFG_IDX_W      = 3;
	localparam int NODE_W         = 3;
	localparam int STEP_W         = 5;
	localparam int NUM_STEPS      = 28;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IND_COND_RE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IND_COND_IM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IND_HIST_RE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IND_HIST_IM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_COND_RE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_COND_IM  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_PRESENT = 3'd6;

	// coefficient select
	localparam logic [2:0] CS_GLR = 3'd0;
	localparam logic [2:0] CS_GLI = 3'd1;
	localparam logic [2:0] CS_HRE = 3'd2;
	localparam logic [2:0] CS_HIM = 3'd3;
	localparam logic [2:0] CS_GCR = 3'd4;
	localparam logic [2:0] CS_GCI = 3'd5;

	// multiplier data operand select
	localparam logic [2:0] OS_DV_RE = 3'd0;
	localparam logic [2:0] OS_DV_IM = 3'd1;
	localparam logic [2:0] OS_IL_RE = 3'd2;
	localparam logic [2:0] OS_IL_IM = 3'd3;
	localparam logic [2:0] OS_N1_RE = 3'd4;
	localparam logic [2:0] OS_N1_IM = 3'd5;
	localparam logic [2:0] OS_N2_RE = 3'd6;
	localparam logic [2:0] OS_N2_IM = 3'd7;

	// accumulator start value on the first term of a sum
	localparam logic [3:0] IN_ZERO   = 4'd0;
	localparam logic [3:0] IN_IS_RE  = 4'd1;
	localparam logic [3:0] IN_IS_IM  = 4'd2;
	localparam logic [3:0] IN_NS1_RE = 4'd3;
	localparam logic [3:0] IN_NS1_IM = 4'd4;
	localparam logic [3:0] IN_C1_RE  = 4'd5;
	localparam logic [3:0] IN_C1_IM  = 4'd6;
	localparam logic [3:0] IN_NS2_RE = 4'd7;
	localparam logic [3:0] IN_NS2_IM = 4'd8;
	localparam logic [3:0] IN_C2_RE  = 4'd9;
	localparam logic [3:0] IN_C2_IM  = 4'd10;

	// destination of a finished sum
	localparam logic [3:0] DS_IL_RE = 4'd0;
	localparam logic [3:0] DS_IL_IM = 4'd1;
	localparam logic [3:0] DS_C1_RE = 4'd2;
	localparam logic [3:0] DS_C1_IM = 4'd3;
	localparam logic [3:0] DS_S1_RE = 4'd4;
	localparam logic [3:0] DS_S1_IM = 4'd5;
	localparam logic [3:0] DS_C2_RE = 4'd6;
	localparam logic [3:0] DS_C2_IM = 4'd7;
	localparam logic [3:0] DS_S2_RE = 4'd8;
	localparam logic [3:0] DS_S2_IM = 4'd9;
	localparam logic [3:0] DS_IS_RE = 4'd10;
	localparam logic [3:0] DS_IS_IM = 4'd11;

	typedef struct packed {
		logic [2:0] coef_sel;
		logic [2:0] opnd_sel;
		logic       sub;
		logic       first;
		logic       last;
		logic [3:0] init_sel;
		logic [3:0] dest;
	} uop_t;

	typedef struct packed {
		logic load;
		logic issue;
		uop_t uop;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_hold;
	} stat_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] glr;
		logic signed [COEF_W-1:0] gli;
		logic signed [COEF_W-1:0] hre;
		logic signed [COEF_W-1:0] him;
		logic signed [COEF_W-1:0] gcr;
		logic signed [COEF_W-1:0] gci;
		logic [NODE_W-1:0]        present;
	} cfg_t;

	function automatic uop_t mk_uop(input logic [2:0] coef_sel, input logic [2:0] opnd_sel,
		input logic sub, input logic first, input logic last,
		input logic [3:0] init_sel, input logic [3:0] dest);
		uop_t u;
		u.coef_sel = coef_sel;
		u.opnd_sel = opnd_sel;
		u.sub      = sub;
		u.first    = first;
		u.last     = last;
		u.init_sel = init_sel;
		u.dest     = dest;
		return u;
	endfunction

	// One product per step. Inductor current first, then both capacitors,
	// then the inductor source, which needs the new inductor current.
	function automatic uop_t uop_lookup(input logic [STEP_W-1:0] step);
		uop_t u;
		unique case (step)
			5'd0:  u = mk_uop(CS_GLR, OS_DV_RE, 1'b0, 1'b1, 1'b0, IN_IS_RE, DS_IL_RE);
			5'd1:  u = mk_uop(CS_GLI, OS_DV_IM, 1'b1, 1'b0, 1'b1, IN_ZERO, DS_IL_RE);
			5'd2:  u = mk_uop(CS_GLI, OS_DV_RE, 1'b0, 1'b1, 1'b0, IN_IS_IM, DS_IL_IM);
			5'd3:  u = mk_uop(CS_GLR, OS_DV_IM, 1'b0, 1'b0, 1'b1, IN_ZERO, DS_IL_IM);
			5'd4:  u = mk_uop(CS_GCR, OS_N1_RE, 1'b0, 1'b1, 1'b0, IN_NS1_RE, DS_C1_RE);
			5'd5:  u = mk_uop(CS_GCI, OS_N1_IM, 1'b1, 1'b0, 1'b1, IN_ZERO, DS_C1_RE);
			5'd6:  u = mk_uop(CS_GCI, OS_N1_RE, 1'b0, 1'b1, 1'b0, IN_NS1_IM, DS_C1_IM);
			5'd7:  u = mk_uop(CS_GCR, OS_N1_IM, 1'b0, 1'b0, 1'b1, IN_ZERO, DS_C1_IM);
			5'd8:  u = mk_uop(CS_GCR, OS_N1_RE, 1'b0, 1'b1, 1'b0, IN_C1_RE, DS_S1_RE);
			5'd9:  u = mk_uop(CS_GCI, OS_N1_IM, 1'b0, 1'b0, 1'b1, IN_ZERO, DS_S1_RE);
			5'd10: u = mk_uop(CS_GCR, OS_N1_IM, 1'b0, 1'b1, 1'b0, IN_C1_IM, DS_S1_IM);
			5'd11: u = mk_uop(CS_GCI, OS_N1_RE, 1'b1, 1'b0, 1'b1, IN_ZERO, DS_S1_IM);
			5'd12: u = mk_uop(CS_GCR, OS_N2_RE, 1'b0, 1'b1, 1'b0, IN_NS2_RE, DS_C2_RE);
			5'd13: u = mk_uop(CS_GCI, OS_N2_IM, 1'b1, 1'b0, 1'b1, IN_ZERO, DS_C2_RE);
			5'd14: u = mk_uop(CS_GCI, OS_N2_RE, 1'b0, 1'b1, 1'b0, IN_NS2_IM, DS_C2_IM);
			5'd15: u = mk_uop(CS_GCR, OS_N2_IM, 1'b0, 1'b0, 1'b1, IN_ZERO, DS_C2_IM);
			5'd16: u = mk_uop(CS_GCR, OS_N2_RE, 1'b0, 1'b1, 1'b0, IN_C2_RE, DS_S2_RE);
			5'd17: u = mk_uop(CS_GCI, OS_N2_IM, 1'b0, 1'b0, 1'b1, IN_ZERO, DS_S2_RE);
			5'd18: u = mk_uop(CS_GCR, OS_N2_IM, 1'b0, 1'b1, 1'b0, IN_C2_IM, DS_S2_IM);
			5'd19: u = mk_uop(CS_GCI, OS_N2_RE, 1'b1, 1'b0, 1'b1, IN_ZERO, DS_S2_IM);
			5'd20: u = mk_uop(CS_GLR, OS_DV_RE, 1'b0, 1'b1, 1'b0, IN_ZERO, DS_IS_RE);
			5'd21: u = mk_uop(CS_GLI, OS_DV_IM, 1'b1, 1'b0, 1'b0, IN_ZERO, DS_IS_RE);
			5'd22: u = mk_uop(CS_HRE, OS_IL_RE, 1'b0, 1'b0, 1'b0, IN_ZERO, DS_IS_RE);
			5'd23: u = mk_uop(CS_HIM, OS_IL_IM, 1'b1, 1'b0, 1'b1, IN_ZERO, DS_IS_RE);
			5'd24: u = mk_uop(CS_GLI, OS_DV_RE, 1'b0, 1'b1, 1'b0, IN_ZERO, DS_IS_IM);
			5'd25: u = mk_uop(CS_GLR, OS_DV_IM, 1'b0, 1'b0, 1'b0, IN_ZERO, DS_IS_IM);
			5'd26: u = mk_uop(CS_HIM, OS_IL_RE, 1'b0, 1'b0, 1'b0, IN_ZERO, DS_IS_IM);
			5'd27: u = mk_uop(CS_HRE, OS_IL_IM, 1'b0, 1'b0, 1'b1, IN_ZERO, DS_IS_IM);
			default: u = mk_uop(CS_GLR, OS_DV_RE, 1'b0, 1'b0, 1'b0, IN_ZERO, DS_IL_RE);
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/pi_line_phasor_companion_step_top.sv =====
// Channel   Handshake               Payload
// cfg       cfg_we                  cfg_index, cfg_data
// in        in_valid / in_stall     v1_re v1_im v2_re v2_im v3_re v3_im
// out       out_valid / out_stall   inj1_re inj1_im inj2_re inj2_im inj3_re inj3_im
//
// Per item: the accept, then 28 products through the single shared coefficient multiplier,
// then the multiply pipeline drains and the output is loaded; the input stays closed until then.
// Reset (arst_n low) clears coefficients, node mask and all line state to zero.
// Results sit in an output register; the next item is taken while a result waits.
// A finished item waits in the drain state until the output register is free.
`include "pi_line_phasor_companion_step_top_macros.svh"

module pi_line_phasor_companion_step_top #(
	parameter int DATA_WIDTH = pilpc_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pilpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pilpc_pkg::COEF_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [DATA_WIDTH-1:0]      v1_re,
	input  logic signed [DATA_WIDTH-1:0]      v1_im,
	input  logic signed [DATA_WIDTH-1:0]      v2_re,
	input  logic signed [DATA_WIDTH-1:0]      v2_im,
	input  logic signed [DATA_WIDTH-1:0]      v3_re,
	input  logic signed [DATA_WIDTH-1:0]      v3_im,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [DATA_WIDTH-1:0]      inj1_re,
	output logic signed [DATA_WIDTH-1:0]      inj1_im,
	output logic signed [DATA_WIDTH-1:0]      inj2_re,
	output logic signed [DATA_WIDTH-1:0]      inj2_im,
	output logic signed [DATA_WIDTH-1:0]      inj3_re,
	output logic signed [DATA_WIDTH-1:0]      inj3_im
);

	pilpc_pkg::cfg_t  cfg;
	pilpc_pkg::cmd_t  cmd;
	pilpc_pkg::stat_t stat;

	pilpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pilpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	pilpc_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg),
		.stat      (stat),
		.v1_re     (v1_re),
		.v1_im     (v1_im),
		.v2_re     (v2_re),
		.v2_im     (v2_im),
		.v3_re     (v3_re),
		.v3_im     (v3_im),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.inj1_re   (inj1_re),
		.inj1_im   (inj1_im),
		.inj2_re   (inj2_re),
		.inj2_im   (inj2_im),
		.inj3_re   (inj3_re),
		.inj3_im   (inj3_im)
	);

	// an accepted item keeps the input closed until its result is loaded
	`PILPC_ASSERT_NEXT(a_stall_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// a waiting result is never overwritten
	`PILPC_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.load_out, !(out_valid && out_stall))
	// products are only issued while an item is in work
	`PILPC_ASSERT_NOW(a_issue_busy, clk, arst_n, cmd.issue || stat.pipe_busy, in_stall)
	`PILPC_ASSERT_NEXT(a_out_after_load, clk, arst_n, cmd.load_out, out_valid)

endmodule

// ===== rtl/pilpc_cfg.sv =====
module pilpc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pilpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pilpc_pkg::COEF_W-1:0]        cfg_data,
	output pilpc_pkg::cfg_t                     cfg
);

	pilpc_pkg::cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pilpc_pkg::REG_IND_COND_RE:  regs_q.glr <= cfg_data;
				pilpc_pkg::REG_IND_COND_IM:  regs_q.gli <= cfg_data;
				pilpc_pkg::REG_IND_HIST_RE:  regs_q.hre <= cfg_data;
				pilpc_pkg::REG_IND_HIST_IM:  regs_q.him <= cfg_data;
				pilpc_pkg::REG_CAP_COND_RE:  regs_q.gcr <= cfg_data;
				pilpc_pkg::REG_CAP_COND_IM:  regs_q.gci <= cfg_data;
				pilpc_pkg::REG_NODE_PRESENT: regs_q.present <= cfg_data[pilpc_pkg::NODE_W-1:0];
				default: ;  // unmapped index: ignored
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

// ===== rtl/pilpc_ctrl.sv =====
module pilpc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  pilpc_pkg::stat_t   stat,
	output logic               in_stall,
	output pilpc_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	localparam logic [pilpc_pkg::STEP_W-1:0] LAST_STEP =
		pilpc_pkg::STEP_W'(pilpc_pkg::NUM_STEPS - 1);

	logic [1:0]                    state_q;
	logic [pilpc_pkg::STEP_W-1:0]  step_q;

	always_comb begin
		cmd          = '0;
		cmd.uop      = pilpc_pkg::uop_lookup(step_q);
		in_stall     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
				// wait for the last sum to land and for room in the output register
				cmd.load_out = !stat.pipe_busy && !stat.out_hold;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_valid) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (step_q == LAST_STEP) state_q <= ST_DRAIN;
					else step_q <= step_q + 1'b1;
				end
				ST_DRAIN: begin
					if (cmd.load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/pilpc_dp.sv =====
module pilpc_dp #(
	parameter int DATA_WIDTH = pilpc_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pilpc_pkg::cmd_t               cmd,
	input  pilpc_pkg::cfg_t               cfg,
	output pilpc_pkg::stat_t              stat,
	input  logic signed [DATA_WIDTH-1:0]  v1_re,
	input  logic signed [DATA_WIDTH-1:0]  v1_im,
	input  logic signed [DATA_WIDTH-1:0]  v2_re,
	input  logic signed [DATA_WIDTH-1:0]  v2_im,
	input  logic signed [DATA_WIDTH-1:0]  v3_re,
	input  logic signed [DATA_WIDTH-1:0]  v3_im,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic signed [DATA_WIDTH-1:0]  inj1_re,
	output logic signed [DATA_WIDTH-1:0]  inj1_im,
	output logic signed [DATA_WIDTH-1:0]  inj2_re,
	output logic signed [DATA_WIDTH-1:0]  inj2_im,
	output logic signed [DATA_WIDTH-1:0]  inj3_re,
	output logic signed [DATA_WIDTH-1:0]  inj3_im
);

	localparam int CW     = pilpc_pkg::COEF_W;
	localparam int ACC_W  = DATA_WIDTH + 4;
	localparam int PROD_W = CW + DATA_WIDTH;
	localparam int TERM_W = PROD_W - pilpc_pkg::COEF_FRAC + 1;
	localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (pilpc_pkg::COEF_FRAC - 1);

	typedef struct packed {
		logic       first;
		logic       last;
		logic [3:0] init_sel;
		logic [3:0] dest;
	} tag_t;

	function automatic logic signed [ACC_W-1:0] sx(input logic signed [DATA_WIDTH-1:0] v);
		return {{(ACC_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [ACC_W-1:0] x);
		logic [ACC_W-DATA_WIDTH:0] hi;
		hi = x[ACC_W-1:DATA_WIDTH-1];
		if ((&hi) || !(|hi)) return x[DATA_WIDTH-1:0];
		else if (x[ACC_W-1]) return {1'b1, {(DATA_WIDTH-1){1'b0}}};
		else return {1'b0, {(DATA_WIDTH-1){1'b1}}};
	endfunction

	// step state
	logic signed [DATA_WIDTH-1:0] dv_re_q, dv_im_q, n1_re_q, n1_im_q, n2_re_q, n2_im_q;
	logic signed [DATA_WIDTH-1:0] il_re_q, il_im_q, is_re_q, is_im_q;
	logic signed [DATA_WIDTH-1:0] c1_re_q, c1_im_q, s1_re_q, s1_im_q;
	logic signed [DATA_WIDTH-1:0] c2_re_q, c2_im_q, s2_re_q, s2_im_q;
	logic signed [ACC_W-1:0]      acc_q;

	// input masking for grounded nodes
	logic signed [DATA_WIDTH-1:0] v1m_re, v1m_im, v2m_re, v2m_im, v3m_re, v3m_im;

	always_comb begin
		v1m_re = cfg.present[0] ? v1_re : '0;
		v1m_im = cfg.present[0] ? v1_im : '0;
		v2m_re = cfg.present[1] ? v2_re : '0;
		v2m_im = cfg.present[1] ? v2_im : '0;
		v3m_re = cfg.present[2] ? v3_re : '0;
		v3m_im = cfg.present[2] ? v3_im : '0;
	end

	// operand select and sign/magnitude split
	logic signed [CW-1:0]         coef;
	logic signed [DATA_WIDTH-1:0] opnd;
	logic [CW-1:0]                coef_mag;
	logic [DATA_WIDTH-1:0]        opnd_mag;
	logic                         neg_d;
	tag_t                         tag_d;

	always_comb begin
		case (cmd.uop.coef_sel)
			pilpc_pkg::CS_GLR: coef = cfg.glr;
			pilpc_pkg::CS_GLI: coef = cfg.gli;
			pilpc_pkg::CS_HRE: coef = cfg.hre;
			pilpc_pkg::CS_HIM: coef = cfg.him;
			pilpc_pkg::CS_GCR: coef = cfg.gcr;
			pilpc_pkg::CS_GCI: coef = cfg.gci;
			default:           coef = '0;
		endcase
		case (cmd.uop.opnd_sel)
			pilpc_pkg::OS_DV_RE: opnd = dv_re_q;
			pilpc_pkg::OS_DV_IM: opnd = dv_im_q;
			pilpc_pkg::OS_IL_RE: opnd = il_re_q;
			pilpc_pkg::OS_IL_IM: opnd = il_im_q;
			pilpc_pkg::OS_N1_RE: opnd = n1_re_q;
			pilpc_pkg::OS_N1_IM: opnd = n1_im_q;
			pilpc_pkg::OS_N2_RE: opnd = n2_re_q;
			pilpc_pkg::OS_N2_IM: opnd = n2_im_q;
			default:             opnd = '0;
		endcase
		// the most negative value maps to its unsigned magnitude
		coef_mag = coef[CW-1] ? (~coef + 1'b1) : coef;
		opnd_mag = opnd[DATA_WIDTH-1] ? (~opnd + 1'b1) : opnd;
		neg_d    = coef[CW-1] ^ opnd[DATA_WIDTH-1] ^ cmd.uop.sub;
		tag_d.first    = cmd.uop.first;
		tag_d.last     = cmd.uop.last;
		tag_d.init_sel = cmd.uop.init_sel;
		tag_d.dest     = cmd.uop.dest;
	end

	// multiply pipeline: operands, product, rounded signed term
	logic                  valid_s1, valid_s2, valid_s3;
	logic [CW-1:0]         coef_mag_s1;
	logic [DATA_WIDTH-1:0] opnd_mag_s1;
	logic                  neg_s1, neg_s2;
	tag_t                  tag_s1, tag_s2, tag_s3;
	logic [PROD_W-1:0]     prod_s2;
	logic signed [TERM_W-1:0] term_s3;
	logic [PROD_W-1:0]     prod_rnd;
	logic [TERM_W-1:0]     term_mag;

	always_comb begin
		prod_rnd = prod_s2 + RND;
		term_mag = {1'b0, prod_rnd[PROD_W-1:pilpc_pkg::COEF_FRAC]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			coef_mag_s1 <= coef_mag;
			opnd_mag_s1 <= opnd_mag;
			neg_s1      <= neg_d;
			tag_s1      <= tag_d;
		end
		if (valid_s1) begin
			prod_s2 <= PROD_W'(coef_mag_s1) * PROD_W'(opnd_mag_s1);
			neg_s2  <= neg_s1;
			tag_s2  <= tag_s1;
		end
		if (valid_s2) begin
			term_s3 <= neg_s2 ? -term_mag : term_mag;
			tag_s3  <= tag_s2;
		end
	end

	// accumulate
	logic signed [ACC_W-1:0]      init_val, sum;
	logic signed [DATA_WIDTH-1:0] sum_sat;

	always_comb begin
		case (tag_s3.init_sel)
			pilpc_pkg::IN_IS_RE:  init_val = sx(is_re_q);
			pilpc_pkg::IN_IS_IM:  init_val = sx(is_im_q);
			pilpc_pkg::IN_NS1_RE: init_val = -sx(s1_re_q);
			pilpc_pkg::IN_NS1_IM: init_val = -sx(s1_im_q);
			pilpc_pkg::IN_C1_RE:  init_val = sx(c1_re_q);
			pilpc_pkg::IN_C1_IM:  init_val = sx(c1_im_q);
			pilpc_pkg::IN_NS2_RE: init_val = -sx(s2_re_q);
			pilpc_pkg::IN_NS2_IM: init_val = -sx(s2_im_q);
			pilpc_pkg::IN_C2_RE:  init_val = sx(c2_re_q);
			pilpc_pkg::IN_C2_IM:  init_val = sx(c2_im_q);
			default:              init_val = '0;
		endcase
		sum = (tag_s3.first ? init_val : acc_q)
			+ {{(ACC_W-TERM_W){term_s3[TERM_W-1]}}, term_s3};
		sum_sat = sat(sum);
	end

	always_ff @(posedge clk) begin
		if (valid_s3) acc_q <= sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_re_q <= '0; dv_im_q <= '0;
			n1_re_q <= '0; n1_im_q <= '0;
			n2_re_q <= '0; n2_im_q <= '0;
			il_re_q <= '0; il_im_q <= '0;
			is_re_q <= '0; is_im_q <= '0;
			c1_re_q <= '0; c1_im_q <= '0;
			s1_re_q <= '0; s1_im_q <= '0;
			c2_re_q <= '0; c2_im_q <= '0;
			s2_re_q <= '0; s2_im_q <= '0;
		end else begin
			if (cmd.load) begin
				dv_re_q <= sat(sx(v3m_re) - sx(v2m_re));
				dv_im_q <= sat(sx(v3m_im) - sx(v2m_im));
				n1_re_q <= v1m_re;
				n1_im_q <= v1m_im;
				n2_re_q <= v2m_re;
				n2_im_q <= v2m_im;
			end
			if (valid_s3 && tag_s3.last) begin
				case (tag_s3.dest)
					pilpc_pkg::DS_IL_RE: il_re_q <= sum_sat;
					pilpc_pkg::DS_IL_IM: il_im_q <= sum_sat;
					pilpc_pkg::DS_C1_RE: c1_re_q <= sum_sat;
					pilpc_pkg::DS_C1_IM: c1_im_q <= sum_sat;
					pilpc_pkg::DS_S1_RE: s1_re_q <= sum_sat;
					pilpc_pkg::DS_S1_IM: s1_im_q <= sum_sat;
					pilpc_pkg::DS_C2_RE: c2_re_q <= sum_sat;
					pilpc_pkg::DS_C2_IM: c2_im_q <= sum_sat;
					pilpc_pkg::DS_S2_RE: s2_re_q <= sum_sat;
					pilpc_pkg::DS_S2_IM: s2_im_q <= sum_sat;
					pilpc_pkg::DS_IS_RE: is_re_q <= sum_sat;
					pilpc_pkg::DS_IS_IM: is_im_q <= sum_sat;
					default: ;
				endcase
			end
		end
	end

	// output register
	logic out_valid_q;
	logic signed [DATA_WIDTH-1:0] inj1_re_q, inj1_im_q, inj2_re_q, inj2_im_q;
	logic signed [DATA_WIDTH-1:0] inj3_re_q, inj3_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_out) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			inj1_re_q <= cfg.present[0] ? s1_re_q : '0;
			inj1_im_q <= cfg.present[0] ? s1_im_q : '0;
			inj2_re_q <= cfg.present[1] ? sat(sx(is_re_q) + sx(s2_re_q)) : '0;
			inj2_im_q <= cfg.present[1] ? sat(sx(is_im_q) + sx(s2_im_q)) : '0;
			inj3_re_q <= cfg.present[2] ? sat(-sx(is_re_q)) : '0;
			inj3_im_q <= cfg.present[2] ? sat(-sx(is_im_q)) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign inj1_re   = inj1_re_q;
	assign inj1_im   = inj1_im_q;
	assign inj2_re   = inj2_re_q;
	assign inj2_im   = inj2_im_q;
	assign inj3_re   = inj3_re_q;
	assign inj3_im   = inj3_im_q;

	assign stat.pipe_busy = valid_s1 || valid_s2 || valid_s3;
	assign stat.out_hold  = out_valid_q && out_stall;

endmodule
